// File: hdl/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants of the block RMS history meter: sequencer
// states, shared root/divide unit command and status, register indexes.
// ----------------------------------------------------------------------------
package rbm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_LOG2_BLOCK    = 2'd1;
  localparam logic [1:0] CFG_CAPTURE_EN    = 2'd2;

  localparam logic [3:0] RST_CHANNEL_COUNT = 4'd2;
  localparam logic [3:0] RST_LOG2_BLOCK    = 4'd6;
  localparam logic [3:0] LOG2_BLOCK_MAX    = 4'd12;

  // step counts of the shared unit
  localparam logic [5:0] DIV_STEPS  = 6'd32;
  localparam logic [5:0] ROOT_STEPS = 6'd16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SMP_SQ,
    ST_SMP_ACC,
    ST_SMP_WR,
    ST_Q_SETUP,
    ST_Q_EMPTY,
    ST_Q_CHINIT,
    ST_Q_ISSUE,
    ST_Q_RD,
    ST_UNIT_WAIT,
    ST_Q_ACC1,
    ST_Q_ACC2,
    ST_Q_E2,
    ST_Q_M32,
    ST_Q_MSQ,
    ST_Q_MEAN,
    ST_Q_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic root;   // 1: square root, 0: divide
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// File: hdl/rbm_ram.sv
// ----------------------------------------------------------------------------
// rbm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rbm_root_div.sv
// ----------------------------------------------------------------------------
// rbm_root_div
// Shared restoring unit: 32-bit quotient division (one bit a cycle) or
// 16-bit floor square root of a 32-bit value (two bits a cycle).
// ----------------------------------------------------------------------------
module rbm_root_div #(
  parameter int NW = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbm_pkg::unit_cmd_t cmd,
  input  logic [NW+31:0]     opa,
  input  logic [NW-1:0]      opb,
  output rbm_pkg::unit_sts_t sts,
  output logic [31:0]        res
);

  localparam int U_W = (NW + 1 > 19) ? NW + 1 : 19;

  logic [U_W-1:0] rem_r;
  logic [31:0]    quo_r;
  logic [31:0]    src_r;
  logic [NW-1:0]  div_r;
  logic [5:0]     cnt_r;
  logic           root_r;
  logic           busy_r;
  logic           done_r;

  logic [U_W-1:0] sh;
  logic [U_W-1:0] trial;
  logic           ge;
  logic [U_W-1:0] diff;

  always_comb begin
    if (root_r) begin
      sh    = {rem_r[U_W-3:0], src_r[31:30]};
      trial = U_W'({quo_r[15:0], 2'b01});
    end else begin
      sh    = {rem_r[U_W-2:0], src_r[31]};
      trial = U_W'(div_r);
    end
    ge   = (sh >= trial);
    diff = sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      // dividend top part is below the divisor, so 32 steps cover the quotient
      rem_r  <= cmd.root ? '0 : U_W'(opa[NW+31:32]);
      src_r  <= opa[31:0];
      div_r  <= opb;
      quo_r  <= '0;
      root_r <= cmd.root;
      cnt_r  <= cmd.root ? rbm_pkg::ROOT_STEPS : rbm_pkg::DIV_STEPS;
    end else if (busy_r) begin
      rem_r <= ge ? diff : sh;
      quo_r <= {quo_r[30:0], ge};
      src_r <= root_r ? {src_r[29:0], 2'b00} : {src_r[30:0], 1'b0};
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = quo_r;

endmodule

// File: hdl/block_rms_history_meter.sv
// ----------------------------------------------------------------------------
// block_rms_history_meter
// Per-channel block mean-square meter with a ring history and windowed
// RMS / min / max / variance queries.
// ----------------------------------------------------------------------------
// Sample word: square, accumulate and, when it closes a channel of a block,
// store; ready drops meanwhile.
// Query word: per channel, the shared root/divide unit runs one root per block
// of the window, then three divides and one root. Results leave via an output
// register; the sequencer stalls only when that register is still full.
// Reset (synchronous, rst_n low) clears the history pointers and partial
// block and loads the configuration defaults; the ring RAM is not cleared
// and needs no clearing pass.
module block_rms_history_meter #(
  parameter int RING_DEPTH   = 65536,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [16:0]                   in_window_blocks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_channel,
  output logic [15:0]                   out_mean_rms,
  output logic [15:0]                   out_min_rms,
  output logic [15:0]                   out_max_rms,
  output logic [31:0]                   out_var_rms,
  output logic [16:0]                   out_blocks_used,
  output logic                          out_status,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [3:0]                    cfg_wdata
);

  localparam int SB        = SAMPLE_BITS;
  localparam int PRE_SHIFT = (2 * SB + 11 > 64) ? (2 * SB + 11 - 64) : 0;
  localparam int FRAC_BITS = 2 * (SB - 1) - PRE_SHIFT;
  localparam int SQ_W      = 2 * SB - 1 - PRE_SHIFT;
  localparam int ACC_W     = SQ_W + 12;
  localparam int IW        = $clog2(RING_DEPTH);
  localparam int NW        = $clog2(RING_DEPTH + 1);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W     = $clog2(MAX_CHANNELS + 1);
  localparam int AW        = IW + CH_W;

  rbm_pkg::state_t state_r, state_nxt, op_ret_r, op_ret_nxt;

  // configuration and history control
  logic [3:0]       cc_r, lg_r;
  logic             cap_r;
  logic [IW-1:0]    wi_r;
  logic [NW-1:0]    stored_r;
  logic [ACC_W-1:0] acc_r;
  logic [11:0]      cnt_r;
  logic [NCH_W-1:0] chc_r;

  // datapath
  logic [SB-1:0]    sample_r;
  logic [16:0]      win_r;
  logic [SQ_W-1:0]  sq_r;
  logic [NW-1:0]    n_r, b_r;
  logic [IW-1:0]    start_r, idx_r;
  logic [NCH_W-1:0] ch_r;
  logic [31:0]      mos_r;
  logic [NW+31:0]   sum_mos_r, sum_rms2_r;
  logic [NW+15:0]   sum_rms_r;
  logic [15:0]      lo_r, hi_r;
  logic [31:0]      rms2_r, e2_r, msq_r, var_r;

  logic             out_valid_r;
  logic [2:0]       out_channel_r;
  logic [15:0]      out_mean_r, out_min_r, out_max_r;
  logic [31:0]      out_var_r;
  logic [16:0]      out_used_r;
  logic             out_status_r, out_last_r;

  rbm_pkg::unit_cmd_t ucmd;
  rbm_pkg::unit_sts_t ust;
  logic [NW+31:0]     u_a;
  logic [31:0]        ures;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  logic               out_free, out_load;

  // effective configuration
  logic [NCH_W-1:0] nch;
  logic [3:0]       lg_eff;
  always_comb begin
    if (cc_r == 4'd0) begin
      nch = NCH_W'(1);
    end else if (32'(cc_r) > MAX_CHANNELS) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = NCH_W'(cc_r);
    end
    lg_eff = (lg_r > rbm_pkg::LOG2_BLOCK_MAX) ? rbm_pkg::LOG2_BLOCK_MAX : lg_r;
  end

  // sample path
  logic [SB-1:0]      mag;
  logic [2*SB-1:0]    sq_full;
  logic [ACC_W-1:0]   acc_sum;
  logic               blk_end;
  logic [6:0]         shamt;
  logic [ACC_W+31:0]  mos_wide;
  logic [31:0]        mos_sat;
  logic [NCH_W-1:0]   chc_inc;
  logic               blk_wrap;
  logic [31:0]        wi_inc;

  assign mag      = sample_r[SB-1] ? (~sample_r + 1'b1) : sample_r;
  assign sq_full  = mag * mag;
  assign acc_sum  = acc_r + ACC_W'(sq_r);
  assign blk_end  = !(13'(cnt_r) + 13'd1 < (13'd1 << lg_eff));
  assign shamt    = 7'(FRAC_BITS) + 7'(lg_eff);
  assign mos_wide = {acc_r, 32'd0} >> shamt;
  assign mos_sat  = (|mos_wide[ACC_W+31:32]) ? 32'hFFFF_FFFF : mos_wide[31:0];
  assign chc_inc  = chc_r + 1'b1;
  assign blk_wrap = (32'(chc_inc) >= 32'(nch));
  assign wi_inc   = 32'(wi_r) + 32'd1;

  // query setup
  logic [31:0] win_c, n_c, start_c;
  always_comb begin
    win_c = (32'(win_r) > 32'(stored_r)) ? 32'(stored_r) : 32'(win_r);
    n_c   = (win_c == 32'd0) ? 32'd1 : win_c;
    start_c = (32'(wi_r) >= n_c) ? 32'(wi_r) - n_c : 32'(wi_r) + RING_DEPTH - n_c;
  end

  logic [15:0] rms;
  logic [31:0] idx_inc;
  logic        last_blk, last_ch;
  logic [63:0] m32_sq;
  logic [31:0] ch_wide;

  assign rms      = ures[15:0];
  assign idx_inc  = 32'(idx_r) + 32'd1;
  assign last_blk = (32'(b_r) + 32'd1 == 32'(n_r));
  assign last_ch  = (32'(ch_r) + 32'd1 == 32'(nch));
  assign m32_sq   = ures * ures;
  assign ch_wide  = 32'(ch_r);
  assign out_free = !out_valid_r || out_ready;

  assign ram_waddr = {wi_r, chc_r[CH_W-1:0]};
  assign ram_wdata = mos_sat;
  assign ram_raddr = {idx_r, ch_r[CH_W-1:0]};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    op_ret_nxt = op_ret_r;
    ucmd       = '0;
    u_a        = '0;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      rbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func) begin
            state_nxt = rbm_pkg::ST_Q_SETUP;
          end else if (cap_r) begin
            state_nxt = rbm_pkg::ST_SMP_SQ;
          end
        end
      end
      rbm_pkg::ST_SMP_SQ:  state_nxt = rbm_pkg::ST_SMP_ACC;
      rbm_pkg::ST_SMP_ACC: state_nxt = blk_end ? rbm_pkg::ST_SMP_WR : rbm_pkg::ST_IDLE;
      rbm_pkg::ST_SMP_WR: begin
        ram_we    = 1'b1;
        state_nxt = rbm_pkg::ST_IDLE;
      end
      rbm_pkg::ST_Q_SETUP: begin
        state_nxt = (stored_r == '0) ? rbm_pkg::ST_Q_EMPTY : rbm_pkg::ST_Q_CHINIT;
      end
      rbm_pkg::ST_Q_EMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = rbm_pkg::ST_IDLE;
        end
      end
      rbm_pkg::ST_Q_CHINIT: state_nxt = rbm_pkg::ST_Q_ISSUE;
      rbm_pkg::ST_Q_ISSUE:  state_nxt = rbm_pkg::ST_Q_RD;
      rbm_pkg::ST_Q_RD: begin
        ucmd       = '{start: 1'b1, root: 1'b1};
        u_a        = (NW + 32)'(ram_rdata);
        op_ret_nxt = rbm_pkg::ST_Q_ACC1;
        state_nxt  = rbm_pkg::ST_UNIT_WAIT;
      end
      rbm_pkg::ST_UNIT_WAIT: begin
        if (ust.done) begin
          state_nxt = op_ret_r;
        end
      end
      rbm_pkg::ST_Q_ACC1: state_nxt = rbm_pkg::ST_Q_ACC2;
      rbm_pkg::ST_Q_ACC2: begin
        state_nxt = last_blk ? rbm_pkg::ST_Q_E2 : rbm_pkg::ST_Q_ISSUE;
      end
      rbm_pkg::ST_Q_E2: begin
        ucmd       = '{start: 1'b1, root: 1'b0};
        u_a        = sum_rms2_r;
        op_ret_nxt = rbm_pkg::ST_Q_M32;
        state_nxt  = rbm_pkg::ST_UNIT_WAIT;
      end
      rbm_pkg::ST_Q_M32: begin
        ucmd       = '{start: 1'b1, root: 1'b0};
        u_a        = {sum_rms_r, 16'd0};
        op_ret_nxt = rbm_pkg::ST_Q_MSQ;
        state_nxt  = rbm_pkg::ST_UNIT_WAIT;
      end
      rbm_pkg::ST_Q_MSQ: begin
        ucmd       = '{start: 1'b1, root: 1'b0};
        u_a        = sum_mos_r;
        op_ret_nxt = rbm_pkg::ST_Q_MEAN;
        state_nxt  = rbm_pkg::ST_UNIT_WAIT;
      end
      rbm_pkg::ST_Q_MEAN: begin
        ucmd       = '{start: 1'b1, root: 1'b1};
        u_a        = (NW + 32)'(ures);
        op_ret_nxt = rbm_pkg::ST_Q_EMIT;
        state_nxt  = rbm_pkg::ST_UNIT_WAIT;
      end
      rbm_pkg::ST_Q_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = last_ch ? rbm_pkg::ST_IDLE : rbm_pkg::ST_Q_CHINIT;
        end
      end
      default: state_nxt = rbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rbm_pkg::ST_IDLE;
      op_ret_r <= rbm_pkg::ST_IDLE;
    end else begin
      state_r  <= state_nxt;
      op_ret_r <= op_ret_nxt;
    end
  end

  // configuration, history pointers and block accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= rbm_pkg::RST_CHANNEL_COUNT;
      lg_r     <= rbm_pkg::RST_LOG2_BLOCK;
      cap_r    <= 1'b0;
      wi_r     <= '0;
      stored_r <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
      chc_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rbm_pkg::CFG_CHANNEL_COUNT || cfg_index == rbm_pkg::CFG_LOG2_BLOCK ||
          cfg_index == rbm_pkg::CFG_CAPTURE_EN) begin
        // a write to any of the three configuration registers drops the history
        wi_r     <= '0;
        stored_r <= '0;
        acc_r    <= '0;
        cnt_r    <= '0;
        chc_r    <= '0;
      end
      if (cfg_index == rbm_pkg::CFG_CHANNEL_COUNT) cc_r  <= cfg_wdata;
      if (cfg_index == rbm_pkg::CFG_LOG2_BLOCK)    lg_r  <= cfg_wdata;
      if (cfg_index == rbm_pkg::CFG_CAPTURE_EN)    cap_r <= cfg_wdata[0];
    end else if (state_r == rbm_pkg::ST_SMP_ACC) begin
      acc_r <= acc_sum;
      cnt_r <= blk_end ? 12'd0 : cnt_r + 12'd1;
    end else if (state_r == rbm_pkg::ST_SMP_WR) begin
      acc_r <= '0;
      if (blk_wrap) begin
        chc_r <= '0;
        wi_r  <= (wi_inc == 32'(RING_DEPTH)) ? '0 : IW'(wi_inc);
        if (32'(stored_r) < 32'(RING_DEPTH)) begin
          stored_r <= stored_r + 1'b1;
        end
      end else begin
        chc_r <= chc_inc;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      rbm_pkg::ST_IDLE: begin
        if (in_valid) begin
          sample_r <= in_sample;
          win_r    <= in_window_blocks;
        end
      end
      rbm_pkg::ST_SMP_SQ: sq_r <= SQ_W'(sq_full >> PRE_SHIFT);
      rbm_pkg::ST_Q_SETUP: begin
        n_r     <= NW'(n_c);
        start_r <= IW'(start_c);
        ch_r    <= '0;
      end
      rbm_pkg::ST_Q_CHINIT: begin
        sum_mos_r  <= '0;
        sum_rms_r  <= '0;
        sum_rms2_r <= '0;
        b_r        <= '0;
        idx_r      <= start_r;
      end
      rbm_pkg::ST_Q_RD: mos_r <= ram_rdata;
      rbm_pkg::ST_Q_ACC1: begin
        rms2_r    <= rms * rms;
        sum_mos_r <= sum_mos_r + (NW + 32)'(mos_r);
        sum_rms_r <= sum_rms_r + (NW + 16)'(rms);
        if (b_r == '0 || rms < lo_r) lo_r <= rms;
        if (b_r == '0 || rms > hi_r) hi_r <= rms;
      end
      rbm_pkg::ST_Q_ACC2: begin
        sum_rms2_r <= sum_rms2_r + (NW + 32)'(rms2_r);
        b_r        <= b_r + 1'b1;
        idx_r      <= (idx_inc == 32'(RING_DEPTH)) ? '0 : IW'(idx_inc);
      end
      rbm_pkg::ST_Q_M32: e2_r <= ures;
      rbm_pkg::ST_Q_MSQ: msq_r <= m32_sq[63:32];
      rbm_pkg::ST_Q_MEAN: var_r <= (e2_r > msq_r) ? e2_r - msq_r : 32'd0;
      rbm_pkg::ST_Q_EMIT: begin
        if (out_free && !last_ch) ch_r <= ch_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == rbm_pkg::ST_Q_EMPTY) begin
        out_channel_r <= '0;
        out_mean_r    <= '0;
        out_min_r     <= '0;
        out_max_r     <= '0;
        out_var_r     <= '0;
        out_used_r    <= '0;
        out_status_r  <= 1'b1;
        out_last_r    <= 1'b1;
      end else begin
        out_channel_r <= ch_wide[2:0];
        out_mean_r    <= ures[15:0];
        out_min_r     <= lo_r;
        out_max_r     <= hi_r;
        out_var_r     <= var_r;
        out_used_r    <= 17'(n_r);
        out_status_r  <= 1'b0;
        out_last_r    <= last_ch;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_mean_rms    = out_mean_r;
  assign out_min_rms     = out_min_r;
  assign out_max_rms     = out_max_r;
  assign out_var_rms     = out_var_r;
  assign out_blocks_used = out_used_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  rbm_root_div #(
    .NW(NW)
  ) u_root_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ucmd),
    .opa  (u_a),
    .opb  (n_r),
    .sts  (ust),
    .res  (ures)
  );

  rbm_ram #(
    .WIDTH(32),
    .DEPTH(RING_DEPTH << CH_W)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_r) <= 32'(RING_DEPTH))
    else $error("stored block count beyond ring depth");

  a_wi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wi_r) < 32'(RING_DEPTH))
    else $error("write index beyond ring depth");

  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    ust.done |-> state_r == rbm_pkg::ST_UNIT_WAIT)
    else $error("shared unit finished while sequencer not waiting");

  a_query_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func) |=> !in_ready)
    else $error("query word did not hold off the input");

endmodule
